// ----- rtl/core/cbt_pkg.sv -----
package cbt_pkg;

  // sample counter and configuration register width
  localparam int CNT_W      = 6;
  // curve parameter t and u = 1 - t, unsigned Q1.16
  localparam int T_W        = 17;
  localparam int T_FRAC     = 16;
  localparam int NUM_AXES   = 3;
  localparam int NUM_PTS    = 4;
  localparam int NUM_COORDS = NUM_AXES * NUM_PTS;
  // bernstein weights sum to 2^48
  localparam int W_FRAC     = 3 * T_FRAC;
  localparam int W_W        = W_FRAC + 1;
  // weights are split in two halves before the coordinate products
  localparam int W_SPLIT    = 24;

  localparam logic [CNT_W-1:0] RESET_SAMPLES = 6'd40;
  localparam logic [CNT_W-1:0] MAX_SAMPLES   = 6'd63;
  localparam logic [T_W-1:0]   T_ONE         = 17'h10000;

  // floor(65536 / n), entry 0 unused
  localparam logic [T_W-1:0] STEP_Q_TABLE [64] = '{
    17'd0,     17'd65536, 17'd32768, 17'd21845, 17'd16384, 17'd13107, 17'd10922, 17'd9362,
    17'd8192,  17'd7281,  17'd6553,  17'd5957,  17'd5461,  17'd5041,  17'd4681,  17'd4369,
    17'd4096,  17'd3855,  17'd3640,  17'd3449,  17'd3276,  17'd3120,  17'd2978,  17'd2849,
    17'd2730,  17'd2621,  17'd2520,  17'd2427,  17'd2340,  17'd2259,  17'd2184,  17'd2114,
    17'd2048,  17'd1985,  17'd1927,  17'd1872,  17'd1820,  17'd1771,  17'd1724,  17'd1680,
    17'd1638,  17'd1598,  17'd1560,  17'd1524,  17'd1489,  17'd1456,  17'd1424,  17'd1394,
    17'd1365,  17'd1337,  17'd1310,  17'd1285,  17'd1260,  17'd1236,  17'd1213,  17'd1191,
    17'd1170,  17'd1149,  17'd1129,  17'd1110,  17'd1092,  17'd1074,  17'd1057,  17'd1040
  };

  typedef struct packed {
    logic [T_W-1:0] t;
    logic [T_W-1:0] u;
  } tu_t;

  typedef struct packed {
    logic [NUM_PTS-1:0][W_W-1:0] w;
  } weights_t;

endpackage

// ----- rtl/core/cbt_sequencer.sv -----
module cbt_sequencer import cbt_pkg::*; #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    cfg_wr_en,
  input  logic [CNT_W-1:0]                        cfg_wr_data,
  input  logic                                    adv,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [NUM_COORDS-1:0][COORD_WIDTH-1:0]  in_pts,
  output logic                                    s_valid,
  output tu_t                                     s_tu,
  output logic                                    s_last,
  output logic [NUM_COORDS-1:0][COORD_WIDTH-1:0]  s_pts
);

  logic [CNT_W-1:0] spp_r;
  logic             active_r;
  logic [CNT_W-1:0] n_r;
  logic [CNT_W-1:0] idx_r;
  logic [CNT_W-1:0] rem_r;
  logic [CNT_W-1:0] stepr_r;
  logic [T_W-1:0]   tq_r;
  logic [T_W-1:0]   stepq_r;
  logic [NUM_COORDS-1:0][COORD_WIDTH-1:0] pts_r;

  logic             s_valid_r;
  tu_t              s_tu_r;
  logic             s_last_r;
  logic [NUM_COORDS-1:0][COORD_WIDTH-1:0] s_pts_r;

  logic [CNT_W-1:0] n_eff;
  logic [T_W-1:0]   step_q;
  logic [T_W-1:0]   step_prod;
  logic [CNT_W-1:0] step_rem;
  logic [CNT_W:0]   rem_sum;
  logic             wrap;
  logic [CNT_W-1:0] rem_nxt;
  logic [T_W-1:0]   tq_nxt;
  logic             at_last;
  logic             accept;
  logic             issue;

  always_comb begin
    if (spp_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (spp_r > MAX_SAMPLES) begin
      n_eff = MAX_SAMPLES;
    end else begin
      n_eff = spp_r;
    end
  end

  // t step is q + r/n, the fraction kept as a running remainder
  assign step_q    = STEP_Q_TABLE[n_eff];
  assign step_prod = T_W'(n_eff) * step_q;
  assign step_rem  = CNT_W'(T_ONE - step_prod);

  assign rem_sum = {1'b0, rem_r} + {1'b0, stepr_r};
  assign wrap    = (rem_sum >= {1'b0, n_r});
  assign rem_nxt = wrap ? CNT_W'(rem_sum - {1'b0, n_r}) : rem_sum[CNT_W-1:0];
  assign tq_nxt  = tq_r + stepq_r + T_W'(wrap);

  assign at_last  = (idx_r == n_r);
  // next segment enters while the last point of this one is issued
  assign in_ready = adv && (!active_r || at_last);
  assign accept   = in_valid && in_ready;
  assign issue    = adv && active_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spp_r     <= RESET_SAMPLES;
      active_r  <= 1'b0;
      s_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        spp_r <= cfg_wr_data;
      end
      if (accept) begin
        active_r <= 1'b1;
      end else if (issue && at_last) begin
        active_r <= 1'b0;
      end
      if (adv) begin
        s_valid_r <= active_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      idx_r   <= '0;
      tq_r    <= '0;
      rem_r   <= '0;
      n_r     <= n_eff;
      stepq_r <= step_q;
      stepr_r <= step_rem;
      pts_r   <= in_pts;
    end else if (issue) begin
      idx_r <= idx_r + CNT_W'(1);
      tq_r  <= tq_nxt;
      rem_r <= rem_nxt;
    end
    if (adv) begin
      s_tu_r.t <= tq_r;
      s_tu_r.u <= T_ONE - tq_r;
      s_last_r <= at_last;
      s_pts_r  <= pts_r;
    end
  end

  assign s_valid = s_valid_r;
  assign s_tu    = s_tu_r;
  assign s_last  = s_last_r;
  assign s_pts   = s_pts_r;

endmodule

// ----- rtl/core/cbt_weights.sv -----
module cbt_weights import cbt_pkg::*; #(
  parameter int SIDE_W = 193
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_valid,
  input  tu_t               in_tu,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output weights_t          out_w,
  output logic [SIDE_W-1:0] out_side
);

  localparam int SQ_W   = 2 * T_W;
  localparam int TRI_W  = T_W + 2;
  localparam int PROD_W = SQ_W + TRI_W;

  // first stage: squares and tripled terms
  logic              v1_r;
  logic [SQ_W-1:0]   u2_r;
  logic [SQ_W-1:0]   t2_r;
  logic [T_W-1:0]    u_r;
  logic [T_W-1:0]    t_r;
  logic [TRI_W-1:0]  tri_u_r;
  logic [TRI_W-1:0]  tri_t_r;
  logic [SIDE_W-1:0] side1_r;

  // second stage: the four weights
  logic              v2_r;
  weights_t          w_r;
  logic [SIDE_W-1:0] side2_r;

  logic [SQ_W-1:0]   u2_nxt;
  logic [SQ_W-1:0]   t2_nxt;
  logic [TRI_W-1:0]  tri_u_nxt;
  logic [TRI_W-1:0]  tri_t_nxt;
  logic [PROD_W-1:0] prod0;
  logic [PROD_W-1:0] prod1;
  logic [PROD_W-1:0] prod2;
  logic [PROD_W-1:0] prod3;
  weights_t          w_nxt;

  assign u2_nxt    = SQ_W'(in_tu.u) * SQ_W'(in_tu.u);
  assign t2_nxt    = SQ_W'(in_tu.t) * SQ_W'(in_tu.t);
  assign tri_u_nxt = TRI_W'(in_tu.u) + (TRI_W'(in_tu.u) << 1);
  assign tri_t_nxt = TRI_W'(in_tu.t) + (TRI_W'(in_tu.t) << 1);

  assign prod0 = PROD_W'(u2_r) * PROD_W'(u_r);
  assign prod1 = PROD_W'(u2_r) * PROD_W'(tri_t_r);
  assign prod2 = PROD_W'(t2_r) * PROD_W'(tri_u_r);
  assign prod3 = PROD_W'(t2_r) * PROD_W'(t_r);

  // every weight is at most 2^48
  always_comb begin
    w_nxt.w[0] = prod0[W_W-1:0];
    w_nxt.w[1] = prod1[W_W-1:0];
    w_nxt.w[2] = prod2[W_W-1:0];
    w_nxt.w[3] = prod3[W_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      u2_r    <= u2_nxt;
      t2_r    <= t2_nxt;
      u_r     <= in_tu.u;
      t_r     <= in_tu.t;
      tri_u_r <= tri_u_nxt;
      tri_t_r <= tri_t_nxt;
      side1_r <= in_side;
      w_r     <= w_nxt;
      side2_r <= side1_r;
    end
  end

  assign out_valid = v2_r;
  assign out_w     = w_r;
  assign out_side  = side2_r;

endmodule

// ----- rtl/core/cbt_blend.sv -----
module cbt_blend import cbt_pkg::*; #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   adv,
  input  logic                                   in_valid,
  input  logic                                   in_last,
  input  weights_t                               in_w,
  input  logic [NUM_COORDS-1:0][COORD_WIDTH-1:0] in_pts,
  output logic                                   out_valid,
  output logic                                   out_last,
  output logic [NUM_AXES-1:0][COORD_WIDTH-1:0]   out_pt
);

  localparam int LO_W  = COORD_WIDTH + W_SPLIT + 1;
  localparam int HI_W  = COORD_WIDTH + (W_W - W_SPLIT) + 1;
  localparam int SLO_W = LO_W + 2;
  localparam int SHI_W = HI_W + 2;
  localparam int TOT_W = SHI_W + W_SPLIT + 1;

  logic                    v3_r;
  logic                    last3_r;
  logic signed [LO_W-1:0]  plo_r   [NUM_AXES][NUM_PTS];
  logic signed [HI_W-1:0]  phi_r   [NUM_AXES][NUM_PTS];
  logic signed [LO_W-1:0]  plo_nxt [NUM_AXES][NUM_PTS];
  logic signed [HI_W-1:0]  phi_nxt [NUM_AXES][NUM_PTS];

  logic                    v4_r;
  logic                    last4_r;
  logic signed [SLO_W-1:0] slo_r   [NUM_AXES];
  logic signed [SHI_W-1:0] shi_r   [NUM_AXES];
  logic signed [SLO_W-1:0] slo_nxt [NUM_AXES];
  logic signed [SHI_W-1:0] shi_nxt [NUM_AXES];

  logic                    v5_r;
  logic                    last5_r;
  logic signed [TOT_W-1:0] tot     [NUM_AXES];
  logic [NUM_AXES-1:0][COORD_WIDTH-1:0] pt_r;
  logic [NUM_AXES-1:0][COORD_WIDTH-1:0] pt_nxt;

  // coordinate times low and high weight halves
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      for (int k = 0; k < NUM_PTS; k++) begin
        plo_nxt[a][k] = LO_W'($signed(in_pts[k*NUM_AXES+a]))
                      * LO_W'($signed({1'b0, in_w.w[k][W_SPLIT-1:0]}));
        phi_nxt[a][k] = HI_W'($signed(in_pts[k*NUM_AXES+a]))
                      * HI_W'($signed({1'b0, in_w.w[k][W_W-1:W_SPLIT]}));
      end
    end
  end

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      slo_nxt[a] = SLO_W'(plo_r[a][0]) + SLO_W'(plo_r[a][1])
                 + SLO_W'(plo_r[a][2]) + SLO_W'(plo_r[a][3]);
      shi_nxt[a] = SHI_W'(phi_r[a][0]) + SHI_W'(phi_r[a][1])
                 + SHI_W'(phi_r[a][2]) + SHI_W'(phi_r[a][3]);
    end
  end

  // exact sum, then floor by dropping the weight fraction bits
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      tot[a]    = (TOT_W'(shi_r[a]) <<< W_SPLIT) + TOT_W'(slo_r[a]);
      pt_nxt[a] = tot[a][W_FRAC +: COORD_WIDTH];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (adv) begin
      v3_r <= in_valid;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      last3_r <= in_last;
      last4_r <= last3_r;
      last5_r <= last4_r;
      plo_r   <= plo_nxt;
      phi_r   <= phi_nxt;
      slo_r   <= slo_nxt;
      shi_r   <= shi_nxt;
      pt_r    <= pt_nxt;
    end
  end

  assign out_valid = v5_r;
  assign out_last  = last5_r;
  assign out_pt    = pt_r;

endmodule

// ----- rtl/core/cubic_bezier_tessellator_unit.sv -----
// Cubic Bezier tessellator. One input word carries a segment: four 3D control
// points p0..p3, signed Q7.8. For each segment the unit emits N+1 point words
// at t = i/N, i = 0..N, N = samples_per_segment (0 counts as 1); the point at
// t = 1 has out_last_point set. Both channels use valid/ready.
// cfg_wr_en/cfg_wr_data write samples_per_segment; write only while idle.
// After its input word is accepted, the first point of a segment passes the
// sequencer state and output registers, two weight stages and three blend
// stages ending in the output register. The sequencer issues one point per
// cycle unless out_ready holds the pipeline; the next segment is accepted in
// the cycle that issues the last point of the current one, so segments follow
// each other without a gap.
// Reset clears all valid bits and sets samples_per_segment to 40.
// When out_ready is low with a point waiting, the whole pipeline holds and
// in_ready drops; nothing is lost or repeated.
module cubic_bezier_tessellator_unit import cbt_pkg::*; #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [CNT_W-1:0]              cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_p0_x,
  input  logic signed [COORD_WIDTH-1:0] in_p0_y,
  input  logic signed [COORD_WIDTH-1:0] in_p0_z,
  input  logic signed [COORD_WIDTH-1:0] in_p1_x,
  input  logic signed [COORD_WIDTH-1:0] in_p1_y,
  input  logic signed [COORD_WIDTH-1:0] in_p1_z,
  input  logic signed [COORD_WIDTH-1:0] in_p2_x,
  input  logic signed [COORD_WIDTH-1:0] in_p2_y,
  input  logic signed [COORD_WIDTH-1:0] in_p2_z,
  input  logic signed [COORD_WIDTH-1:0] in_p3_x,
  input  logic signed [COORD_WIDTH-1:0] in_p3_y,
  input  logic signed [COORD_WIDTH-1:0] in_p3_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0] out_point_x,
  output logic signed [COORD_WIDTH-1:0] out_point_y,
  output logic signed [COORD_WIDTH-1:0] out_point_z,
  output logic                          out_last_point
);

  localparam int PTS_W  = NUM_COORDS * COORD_WIDTH;
  localparam int SIDE_W = PTS_W + 1;

  logic                                   adv;
  logic [NUM_COORDS-1:0][COORD_WIDTH-1:0] in_pts;

  logic                                   s_valid;
  tu_t                                    s_tu;
  logic                                   s_last;
  logic [NUM_COORDS-1:0][COORD_WIDTH-1:0] s_pts;

  logic                                   w_valid;
  weights_t                               w_w;
  logic [SIDE_W-1:0]                      w_side;
  logic [NUM_COORDS-1:0][COORD_WIDTH-1:0] w_pts;
  logic                                   w_last;

  logic [NUM_AXES-1:0][COORD_WIDTH-1:0]   pt;

  // every stage moves unless a finished point is stuck at the output
  assign adv = !out_valid || out_ready;

  assign in_pts = {in_p3_z, in_p3_y, in_p3_x,
                   in_p2_z, in_p2_y, in_p2_x,
                   in_p1_z, in_p1_y, in_p1_x,
                   in_p0_z, in_p0_y, in_p0_x};

  cbt_sequencer #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .adv         (adv),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_pts      (in_pts),
    .s_valid     (s_valid),
    .s_tu        (s_tu),
    .s_last      (s_last),
    .s_pts       (s_pts)
  );

  cbt_weights #(
    .SIDE_W (SIDE_W)
  ) u_weights (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (s_valid),
    .in_tu     (s_tu),
    .in_side   ({s_last, s_pts}),
    .out_valid (w_valid),
    .out_w     (w_w),
    .out_side  (w_side)
  );

  assign w_pts  = w_side[PTS_W-1:0];
  assign w_last = w_side[SIDE_W-1];

  cbt_blend #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_blend (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (w_valid),
    .in_last   (w_last),
    .in_w      (w_w),
    .in_pts    (w_pts),
    .out_valid (out_valid),
    .out_last  (out_last_point),
    .out_pt    (pt)
  );

  assign out_point_x = pt[0];
  assign out_point_y = pt[1];
  assign out_point_z = pt[2];

endmodule
